/* rtl/gp2x_pkg.sv */
package gp2x_pkg;

  // Coarse position counters and configuration registers share this width.
  localparam int POS_W = 10;
  // Fine grid coordinates carry one more bit.
  localparam int IDX_W = POS_W + 1;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_INTERVALS_X = 1'b0,
    REG_INTERVALS_Y = 1'b1
  } reg_index_t;

  // Fine point kinds, in emission order; the code is also the pending-mask bit.
  typedef enum logic [1:0] {
    KIND_COPY = 2'd0,
    KIND_HORZ = 2'd1,
    KIND_VERT = 2'd2,
    KIND_DIAG = 2'd3
  } kind_t;

  localparam int KINDS = 4;

  // Coordinates and flags of one coarse item handed to the emit stage.
  typedef struct packed {
    pos_t row;
    pos_t col;
    logic done;
  } ctrl_t;

endpackage

/* rtl/gp2x_row_store.sv */
module gp2x_row_store import gp2x_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: the registered read returns the entry from the previous row.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

/* rtl/gp2x_emit.sv */
module gp2x_emit import gp2x_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  ctrl_t        ctrl,
  input  logic [W-1:0] cur,
  input  logic [W-1:0] prev,
  input  logic [W-1:0] up,
  input  logic [W-1:0] diag,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output idx_t         fine_row,
  output idx_t         fine_col,
  output logic [W-1:0] fine_value,
  output logic         last_of_item,
  output logic         grid_done
);

  function automatic logic [W-1:0] mean2(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return s[W:1];
  endfunction

  logic [KINDS-1:0] pending;
  logic [KINDS-1:0] pending_next;
  logic [KINDS-1:0] sel_bit;
  kind_t            sel;
  ctrl_t            held;
  logic [W-1:0]     v_copy;
  logic [W-1:0]     v_horz;
  logic [W-1:0]     v_vert;
  logic [W-1:0]     v_diag;
  idx_t             row2;
  idx_t             col2;

  always_comb begin
    if (pending[KIND_COPY]) begin
      sel = KIND_COPY;
    end else if (pending[KIND_HORZ]) begin
      sel = KIND_HORZ;
    end else if (pending[KIND_VERT]) begin
      sel = KIND_VERT;
    end else begin
      sel = KIND_DIAG;
    end
    sel_bit      = KINDS'(1) << sel;
    pending_next = pending & ~sel_bit;
  end

  assign out_valid    = |pending;
  assign last_of_item = (pending_next == '0);
  assign free         = !out_valid || (out_ready && last_of_item);
  assign grid_done    = held.done;

  assign row2 = {held.row, 1'b0};
  assign col2 = {held.col, 1'b0};

  always_comb begin
    case (sel)
      KIND_COPY: begin
        fine_row   = row2;
        fine_col   = col2;
        fine_value = v_copy;
      end
      KIND_HORZ: begin
        fine_row   = row2;
        fine_col   = col2 - IDX_W'(1);
        fine_value = v_horz;
      end
      KIND_VERT: begin
        fine_row   = row2 - IDX_W'(1);
        fine_col   = col2;
        fine_value = v_vert;
      end
      default: begin
        fine_row   = row2 - IDX_W'(1);
        fine_col   = col2 - IDX_W'(1);
        fine_value = v_diag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending[KIND_COPY] <= 1'b1;
      pending[KIND_HORZ] <= (ctrl.col != '0);
      pending[KIND_VERT] <= (ctrl.row != '0);
      pending[KIND_DIAG] <= (ctrl.col != '0) && (ctrl.row != '0);
    end else if (out_valid && out_ready) begin
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held   <= ctrl;
      v_copy <= cur;
      v_horz <= mean2(prev, cur);
      v_vert <= mean2(up, cur);
      v_diag <= mean2(diag, cur);
    end
  end

endmodule

/* rtl/grid_prolongation_2x_seven_point.sv */
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  ------------------------------------------
// input    in         in_valid / in_ready  coarse_value
// output   out        out_valid/out_ready  fine_row, fine_col, fine_value,
//                                          last_of_item, grid_done
// config   in         cfg_write            cfg_index, cfg_data
//
// Each coarse item yields one to four fine items (four inside the grid, one at its first
// corner), one per cycle on the output while out_ready is high. The output sequencer sets
// the rate; the input register takes the next item while the current one drains. An
// accepted item passes through the input register and then the emit stage.
// Synchronous reset clears counters, history and valid flags; the row store is not
// cleared. A stalled output holds both the emit stage and the input register.
module grid_prolongation_2x_seven_point import gp2x_pkg::*; #(
  parameter int MAX_INTERVALS = 1023,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [0:0]             cfg_index,
  input  logic [POS_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] coarse_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_W-1:0]       fine_row,
  output logic [IDX_W-1:0]       fine_col,
  output logic [VALUE_WIDTH-1:0] fine_value,
  output logic                   last_of_item,
  output logic                   grid_done
);

  localparam int DEPTH = MAX_INTERVALS + 1;
  localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  pos_t intervals_x;
  pos_t intervals_y;
  pos_t clamped;

  pos_t col_pos;
  pos_t row_pos;
  logic row_end;
  logic done_now;

  logic [VALUE_WIDTH-1:0] prev_sample;
  logic [VALUE_WIDTH-1:0] diag_sample;
  logic [VALUE_WIDTH-1:0] up_value;
  logic [AW-1:0]          slot;

  // Input register.
  logic                   a_valid;
  logic [VALUE_WIDTH-1:0] a_cur;
  logic [VALUE_WIDTH-1:0] a_prev;
  ctrl_t                  a_ctrl;

  logic in_acc;
  logic a_move;
  logic emit_free;

  // Saturate interval counts above MAX_INTERVALS, the last store entry.
  assign clamped = (int'(cfg_data) > MAX_INTERVALS) ? POS_W'(MAX_INTERVALS) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      intervals_x <= POS_W'(1);
      intervals_y <= POS_W'(1);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_INTERVALS_X: intervals_x <= clamped;
        REG_INTERVALS_Y: intervals_y <= clamped;
        default: ;
      endcase
    end
  end

  assign a_move   = a_valid && emit_free;
  assign in_ready = !a_valid || a_move;
  assign in_acc   = in_valid && in_ready;

  assign row_end  = (col_pos >= intervals_x);
  assign done_now = row_end && (row_pos >= intervals_y);
  assign slot     = (int'(col_pos) > MAX_INTERVALS) ? AW'(MAX_INTERVALS) : AW'(col_pos);

  // Advance the raster position; wrap at the end of a row and of the grid.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos     <= '0;
      row_pos     <= '0;
      prev_sample <= '0;
    end else if (in_acc) begin
      prev_sample <= coarse_value;
      if (row_end) begin
        col_pos <= '0;
        row_pos <= done_now ? '0 : row_pos + POS_W'(1);
      end else begin
        col_pos <= col_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cur       <= coarse_value;
      a_prev      <= prev_sample;
      a_ctrl.row  <= row_pos;
      a_ctrl.col  <= col_pos;
      a_ctrl.done <= done_now;
    end
  end

  // Keep the upper-left neighbor: the store entry read for the item before.
  always_ff @(posedge clk) begin
    if (rst) begin
      diag_sample <= '0;
    end else if (a_move) begin
      diag_sample <= up_value;
    end
  end

  gp2x_row_store #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_row_store (
    .clk   (clk),
    .en    (in_acc),
    .addr  (slot),
    .wdata (coarse_value),
    .rdata (up_value)
  );

  gp2x_emit #(
    .W (VALUE_WIDTH)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (a_move),
    .ctrl         (a_ctrl),
    .cur          (a_cur),
    .prev         (a_prev),
    .up           (up_value),
    .diag         (diag_sample),
    .free         (emit_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .fine_row     (fine_row),
    .fine_col     (fine_col),
    .fine_value   (fine_value),
    .last_of_item (last_of_item),
    .grid_done    (grid_done)
  );

endmodule
